// ===== rtl/crpi_pkg.sv =====
`timescale 1ns / 1ps

package crpi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int COEF_W     = COORD_BITS + 4;
    localparam int COEF_EXT   = COEF_W - COORD_BITS;
    localparam int U1_W       = COORD_BITS + FRAC_BITS + 5;
    localparam int U2_W       = COORD_BITS + 2 * FRAC_BITS + 5;
    localparam int SPLIT      = U2_W / 2;
    localparam int HI_W       = U2_W - SPLIT;
    localparam int LO_PROD_W  = SPLIT + FRAC_BITS;
    localparam int HI_PROD_W  = HI_W + FRAC_BITS + 1;
    localparam int N_W        = COORD_BITS + 3 * FRAC_BITS + 5;
    localparam int SHIFT      = 3 * FRAC_BITS + 1;
    localparam int Q_W        = N_W - SHIFT;

    localparam int HORNER_DEPTH = 5;
    localparam int ROUND_DEPTH  = 2;
    localparam int PIPE_DEPTH   = HORNER_DEPTH + ROUND_DEPTH;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [FRAC_BITS-1:0]  frac_t;
    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef logic signed [U1_W-1:0]       u1_t;
    typedef logic signed [U2_W-1:0]       u2_t;
    typedef logic signed [N_W-1:0]        acc_t;
    typedef logic signed [Q_W-1:0]        quot_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

endpackage

// ===== rtl/crpi_horner.sv =====
`timescale 1ns / 1ps

module crpi_horner (
    input  logic             aclk,
    input  logic             en,
    input  crpi_pkg::frac_t  t_frac,
    input  crpi_pkg::coord_t p0,
    input  crpi_pkg::coord_t p1,
    input  crpi_pkg::coord_t p2,
    input  crpi_pkg::coord_t p3,
    output crpi_pkg::acc_t   n_out
);

    localparam int EXT  = crpi_pkg::COEF_EXT;
    localparam int CW   = crpi_pkg::COORD_BITS;
    localparam int FW   = crpi_pkg::FRAC_BITS;
    localparam int UP_W = crpi_pkg::U1_W + FW + 1;

    crpi_pkg::coef_t p0e, p1e, p2e, p3e;
    crpi_pkg::coef_t a_next, b_next, c_next;
    crpi_pkg::coef_t a1_reg, b1_reg, c1_reg;
    crpi_pkg::coord_t p1_1_reg, p1_2_reg, p1_3_reg, p1_4_reg;
    crpi_pkg::frac_t t1_reg, t2_reg, t3_reg;
    crpi_pkg::coef_t a2_reg;

    logic signed [crpi_pkg::U1_W-1:0]  cprod;
    crpi_pkg::u1_t u1_next, u1_reg;

    logic signed [UP_W-1:0] uprod;
    crpi_pkg::u2_t u2_next, u2_reg;

    logic        [crpi_pkg::LO_PROD_W-1:0] lo_next, lo_reg;
    logic signed [crpi_pkg::HI_PROD_W-1:0] hi_next, hi_reg;

    crpi_pkg::acc_t n_next, n_reg;

    assign p0e = {{EXT{p0[CW-1]}}, p0};
    assign p1e = {{EXT{p1[CW-1]}}, p1};
    assign p2e = {{EXT{p2[CW-1]}}, p2};
    assign p3e = {{EXT{p3[CW-1]}}, p3};

    always_comb begin
        a_next = p2e - p0e;
        b_next = (p0e <<< 1) - (p1e <<< 2) - p1e + (p2e <<< 2) - p3e;
        c_next = p1e + (p1e <<< 1) - p2e - (p2e <<< 1) + p3e - p0e;
    end

    always_comb begin
        cprod   = crpi_pkg::U1_W'(c1_reg) * crpi_pkg::U1_W'($signed({1'b0, t1_reg}));
        u1_next = cprod + (crpi_pkg::U1_W'(b1_reg) <<< FW);
    end

    always_comb begin
        uprod   = UP_W'(u1_reg) * UP_W'($signed({1'b0, t2_reg}));
        u2_next = crpi_pkg::U2_W'(uprod) + (crpi_pkg::U2_W'(a2_reg) <<< (2 * FW));
    end

    always_comb begin
        lo_next = crpi_pkg::LO_PROD_W'(u2_reg[crpi_pkg::SPLIT-1:0])
                * crpi_pkg::LO_PROD_W'(t3_reg);
        hi_next = crpi_pkg::HI_PROD_W'($signed(u2_reg[crpi_pkg::U2_W-1:crpi_pkg::SPLIT]))
                * crpi_pkg::HI_PROD_W'($signed({1'b0, t3_reg}));
    end

    always_comb begin
        n_next = (crpi_pkg::N_W'(hi_reg) <<< crpi_pkg::SPLIT)
               + $signed({{(crpi_pkg::N_W-crpi_pkg::LO_PROD_W){1'b0}}, lo_reg})
               + (crpi_pkg::N_W'(p1_4_reg) <<< crpi_pkg::SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= a_next;
            b1_reg   <= b_next;
            c1_reg   <= c_next;
            p1_1_reg <= p1;
            t1_reg   <= t_frac;

            u1_reg   <= u1_next;
            a2_reg   <= a1_reg;
            p1_2_reg <= p1_1_reg;
            t2_reg   <= t1_reg;

            u2_reg   <= u2_next;
            p1_3_reg <= p1_2_reg;
            t3_reg   <= t2_reg;

            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            p1_4_reg <= p1_3_reg;

            n_reg    <= n_next;
        end
    end

    assign n_out = n_reg;

endmodule

// ===== rtl/crpi_round.sv =====
`timescale 1ns / 1ps

module crpi_round (
    input  logic             aclk,
    input  logic             en,
    input  crpi_pkg::acc_t   n_in,
    output crpi_pkg::coord_t coord,
    output logic             sat
);

    localparam int CW = crpi_pkg::COORD_BITS;
    localparam int QW = crpi_pkg::Q_W;

    crpi_pkg::acc_t   sum;
    crpi_pkg::quot_t  q_next, q_reg;
    logic             pos_ovf, neg_ovf;
    crpi_pkg::coord_t coord_next, coord_reg;
    logic             sat_next, sat_reg;

    // halves away from zero: negative values add one less before the floor shift
    always_comb begin
        sum    = n_in + (crpi_pkg::N_W'(1) <<< (crpi_pkg::SHIFT - 1))
               - $signed({{(crpi_pkg::N_W-1){1'b0}}, n_in[crpi_pkg::N_W-1]});
        q_next = sum[crpi_pkg::N_W-1:crpi_pkg::SHIFT];
    end

    always_comb begin
        pos_ovf = !q_reg[QW-1] && (|q_reg[QW-2:CW-1]);
        neg_ovf = q_reg[QW-1] && !(&q_reg[QW-2:CW-1]);
        sat_next = pos_ovf || neg_ovf;
        priority if (pos_ovf) begin
            coord_next = crpi_pkg::COORD_MAX;
        end else if (neg_ovf) begin
            coord_next = crpi_pkg::COORD_MIN;
        end else begin
            coord_next = q_reg[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg     <= q_next;
            coord_reg <= coord_next;
            sat_reg   <= sat_next;
        end
    end

    assign coord = coord_reg;
    assign sat   = sat_reg;

endmodule

// ===== rtl/catmull_rom_point_interpolator.sv =====
`timescale 1ns / 1ps
// Catmull-Rom point interpolator.
// Input channel (s_valid/s_ready): fraction t in unsigned Q0.16 and four
// signed 16-bit control points P0..P3. The curve segment between P1 and P2
// is evaluated at t for x and y independently.
// Result channel (m_valid/m_ready): rounded coordinates out_x, out_y
// (halves away from zero) and a saturated flag set when either coordinate
// was clamped to the signed 16-bit range.
// Pipeline: seven register stages (coefficients, three multiplies, final sum,
// two rounding); m_valid rises when a transaction reaches the last stage.
// Throughput: one transaction per cycle unless stalled; one held per stage.
// Stall: while m_valid is high and m_ready low, the whole pipeline holds and
// s_ready drops; the result register keeps its value until taken. Bubbles
// travel with the data, so s_ready is high whenever the result slot is empty.
// Reset: synchronous, active low; clears all valid bits, no result pending.

module catmull_rom_point_interpolator (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  crpi_pkg::frac_t  s_t_frac,
    input  crpi_pkg::coord_t s_p0_x,
    input  crpi_pkg::coord_t s_p0_y,
    input  crpi_pkg::coord_t s_p1_x,
    input  crpi_pkg::coord_t s_p1_y,
    input  crpi_pkg::coord_t s_p2_x,
    input  crpi_pkg::coord_t s_p2_y,
    input  crpi_pkg::coord_t s_p3_x,
    input  crpi_pkg::coord_t s_p3_y,
    output logic             m_valid,
    input  logic             m_ready,
    output crpi_pkg::coord_t m_out_x,
    output crpi_pkg::coord_t m_out_y,
    output logic             m_saturated
);

    localparam int DEPTH = crpi_pkg::PIPE_DEPTH;

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic             en;
    crpi_pkg::acc_t   n_x, n_y;
    logic             sat_x, sat_y;

    assign en      = m_ready || !valid_reg[DEPTH-1];
    assign s_ready = en;
    assign m_valid = valid_reg[DEPTH-1];

    always_comb begin
        valid_next = valid_reg;
        if (en) begin
            valid_next = {valid_reg[DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    crpi_horner u_horner_x (
        .aclk   (aclk),
        .en     (en),
        .t_frac (s_t_frac),
        .p0     (s_p0_x),
        .p1     (s_p1_x),
        .p2     (s_p2_x),
        .p3     (s_p3_x),
        .n_out  (n_x)
    );

    crpi_horner u_horner_y (
        .aclk   (aclk),
        .en     (en),
        .t_frac (s_t_frac),
        .p0     (s_p0_y),
        .p1     (s_p1_y),
        .p2     (s_p2_y),
        .p3     (s_p3_y),
        .n_out  (n_y)
    );

    crpi_round u_round_x (
        .aclk  (aclk),
        .en    (en),
        .n_in  (n_x),
        .coord (m_out_x),
        .sat   (sat_x)
    );

    crpi_round u_round_y (
        .aclk  (aclk),
        .en    (en),
        .n_in  (n_y),
        .coord (m_out_y),
        .sat   (sat_y)
    );

    assign m_saturated = sat_x || sat_y;

endmodule

// ===== rtl/crpi_checker.sv =====
`timescale 1ns / 1ps

module crpi_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_ready,
    input  logic             m_valid,
    input  logic             m_ready,
    input  crpi_pkg::coord_t m_out_x,
    input  crpi_pkg::coord_t m_out_y,
    input  logic             m_saturated
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
            && $stable(m_saturated))
        else $error("stalled result transaction changed");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked while result slot is free");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_out_x == crpi_pkg::COORD_MAX || m_out_x == crpi_pkg::COORD_MIN ||
            m_out_y == crpi_pkg::COORD_MAX || m_out_y == crpi_pkg::COORD_MIN)
        else $error("saturated flag without a clamped coordinate");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while pipeline is stalled");

endmodule

bind catmull_rom_point_interpolator crpi_checker u_crpi_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_x     (m_out_x),
    .m_out_y     (m_out_y),
    .m_saturated (m_saturated)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int TIMEOUT_CYCLES = 300000;
    localparam int DRAIN_CYCLES   = 4 * crpi_pkg::PIPE_DEPTH;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        crpi_pkg::frac_t  t;
        crpi_pkg::coord_t p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
    } span_t;

    typedef struct packed {
        crpi_pkg::coord_t x;
        crpi_pkg::coord_t y;
        logic             sat;
    } point_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    crpi_pkg::frac_t  s_t_frac = '0;
    crpi_pkg::coord_t s_p0_x = '0, s_p0_y = '0, s_p1_x = '0, s_p1_y = '0;
    crpi_pkg::coord_t s_p2_x = '0, s_p2_y = '0, s_p3_x = '0, s_p3_y = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    crpi_pkg::coord_t m_out_x, m_out_y;
    logic             m_saturated;

    point_t pending_points[$];
    int     mismatches = 0;
    int     cycle_count = 0;
    int     src_idle_pct = 0;
    int     snk_stall_pct = 0;
    int     hold_len = 0;

    catmull_rom_point_interpolator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_t_frac    (s_t_frac),
        .s_p0_x      (s_p0_x),
        .s_p0_y      (s_p0_y),
        .s_p1_x      (s_p1_x),
        .s_p1_y      (s_p1_y),
        .s_p2_x      (s_p2_x),
        .s_p2_y      (s_p2_y),
        .s_p3_x      (s_p3_x),
        .s_p3_y      (s_p3_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_saturated (m_saturated)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic crpi_pkg::coord_t spline_coord(input crpi_pkg::frac_t t,
            input crpi_pkg::coord_t q0, input crpi_pkg::coord_t q1,
            input crpi_pkg::coord_t q2, input crpi_pkg::coord_t q3,
            output logic clamped);
        logic signed [127:0] tw, sc, w0, w1, w2, w3, ka, kb, kc, acc, mag, val;
        logic neg;
        tw = {112'd0, t};
        sc = 128'sd1 <<< crpi_pkg::FRAC_BITS;
        w0 = 128'(q0);
        w1 = 128'(q1);
        w2 = 128'(q2);
        w3 = 128'(q3);
        ka = w2 - w0;
        kb = (w0 <<< 1) - (w1 <<< 2) - w1 + (w2 <<< 2) - w3;
        kc = (w1 <<< 1) + w1 - w0 - (w2 <<< 1) - w2 + w3;
        acc = ((kc * tw + kb * sc) * tw + ka * sc * sc) * tw + (w1 <<< 1) * sc * sc * sc;
        neg = acc[127];
        mag = neg ? -acc : acc;
        mag = (mag + sc * sc * sc) >>> crpi_pkg::SHIFT;
        val = neg ? -mag : mag;
        clamped = 1'b0;
        if (val > 128'(crpi_pkg::COORD_MAX)) begin
            clamped = 1'b1;
            return crpi_pkg::COORD_MAX;
        end
        if (val < 128'(crpi_pkg::COORD_MIN)) begin
            clamped = 1'b1;
            return crpi_pkg::COORD_MIN;
        end
        return val[crpi_pkg::COORD_BITS-1:0];
    endfunction

    function automatic point_t catmull_point(input span_t sp);
        point_t r;
        logic   clamp_x, clamp_y;
        r.x = spline_coord(sp.t, sp.p0x, sp.p1x, sp.p2x, sp.p3x, clamp_x);
        r.y = spline_coord(sp.t, sp.p0y, sp.p1y, sp.p2y, sp.p3y, clamp_y);
        r.sat = clamp_x | clamp_y;
        return r;
    endfunction

    function automatic span_t make_span(input int t, input int p0x, input int p0y,
                                        input int p1x, input int p1y, input int p2x,
                                        input int p2y, input int p3x, input int p3y);
        span_t sp;
        sp.t = crpi_pkg::frac_t'(t);
        sp.p0x = crpi_pkg::coord_t'(p0x); sp.p0y = crpi_pkg::coord_t'(p0y);
        sp.p1x = crpi_pkg::coord_t'(p1x); sp.p1y = crpi_pkg::coord_t'(p1y);
        sp.p2x = crpi_pkg::coord_t'(p2x); sp.p2y = crpi_pkg::coord_t'(p2y);
        sp.p3x = crpi_pkg::coord_t'(p3x); sp.p3y = crpi_pkg::coord_t'(p3y);
        return sp;
    endfunction

    function automatic crpi_pkg::coord_t pick_coord(input int mode, input int base);
        int corners[7];
        corners = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        if (mode < 50)
            return crpi_pkg::coord_t'($urandom());
        if (mode < 75)
            return crpi_pkg::coord_t'(base + $urandom_range(0, 1000) - 500);
        return crpi_pkg::coord_t'(corners[$urandom_range(0, 6)]);
    endfunction

    function automatic span_t random_span();
        span_t sp;
        int    mode, base_x, base_y, tsel;
        int    t_corners[4];
        t_corners = '{0, 1, 32768, 65535};
        mode = $urandom_range(0, 99);
        base_x = $urandom_range(0, 60000) - 30000;
        base_y = $urandom_range(0, 60000) - 30000;
        tsel = $urandom_range(0, 9);
        sp.t = (tsel == 0) ? crpi_pkg::frac_t'(t_corners[$urandom_range(0, 3)])
                           : crpi_pkg::frac_t'($urandom());
        sp.p0x = pick_coord(mode, base_x); sp.p0y = pick_coord(mode, base_y);
        sp.p1x = pick_coord(mode, base_x); sp.p1y = pick_coord(mode, base_y);
        sp.p2x = pick_coord(mode, base_x); sp.p2y = pick_coord(mode, base_y);
        sp.p3x = pick_coord(mode, base_x); sp.p3y = pick_coord(mode, base_y);
        return sp;
    endfunction

    task automatic offer_span(input span_t sp);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_t_frac <= sp.t;
        s_p0_x <= sp.p0x; s_p0_y <= sp.p0y;
        s_p1_x <= sp.p1x; s_p1_y <= sp.p1y;
        s_p2_x <= sp.p2x; s_p2_y <= sp.p2y;
        s_p3_x <= sp.p3x; s_p3_y <= sp.p3y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_points = {pending_points, catmull_point(sp)};
    endtask

    task automatic report_mismatch(input string what, input point_t want, input point_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s): expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                     what, want.x, want.y, want.sat, got.x, got.y, got.sat);
    endtask

    always @(posedge aclk) begin
        point_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got.x = m_out_x;
            got.y = m_out_y;
            got.sat = m_saturated;
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected transaction", '0, got);
            end else begin
                want = pending_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.sat !== want.sat)
                    report_mismatch("field value", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_len > 0) begin
            m_ready <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("catmull_rom_point_interpolator test failed");
            $finish;
        end
    end

    task automatic test_directed_corners();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        offer_span(make_span(0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_span(make_span(0, 1234, -999, 32767, -32768, -5, 7, 100, 200));
        offer_span(make_span(65535, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        offer_span(make_span(65535, -32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768));
        offer_span(make_span(32768, -32768, 32767, 32767, -32768, 32767, -32768,
                             -32768, 32767));
        offer_span(make_span(32768, -32768, 10, 32767, 20, 32767, 30, -32768, 40));
        offer_span(make_span(32768, 0, 0, 0, 0, 1, -1, 1, -1));
        offer_span(make_span(32768, 0, 0, 0, 0, -1, 1, -1, 1));
        offer_span(make_span(1, 32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767));
        offer_span(make_span(65535, -32768, 32767, 32767, -32768, -32768, 32767,
                             32767, -32768));
        offer_span(make_span(16384, 32767, -32768, 32767, -32768, 32767, -32768,
                             32767, -32768));
        offer_span(make_span(49152, 0, 0, 100, -100, 200, -200, 300, -300));
        offer_span(make_span(1, 0, 0, -1, 1, 0, 0, 0, 0));
        offer_span(make_span(65535, -21846, 21845, 21845, -21846, -21846, 21845,
                             21845, -21846));
        offer_span(make_span(43690, 21845, -21846, -21846, 21845, 21845, -21846,
                             -21846, 21845));
        offer_span(make_span(32768, 32767, 32767, 32766, -32767, 32767, -32768, 32767, 0));
    endtask

    task automatic test_random_spans(input int count, input int idle_pct, input int stall_pct);
        src_idle_pct = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (count) offer_span(random_span());
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_len = 400;
        repeat (60) offer_span(random_span());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_random_spans(80, 0, 0);
        test_random_spans(80, 77, 0);
        test_random_spans(80, 0, 77);
        test_random_spans(80, 33, 33);
        test_backpressure();
        s_valid <= 1'b0;
        snk_stall_pct = 0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("catmull_rom_point_interpolator test passed");
        end else begin
            $display("catmull_rom_point_interpolator test failed");
        end
        $finish;
    end

endmodule
